// ===== hdl/fof_pkg.sv =====
`timescale 1ns / 1ps

package fof_pkg;

    // Sequencer states of the filter.
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } t_state;

    localparam int unsigned VALUE_W = 32;

endpackage

// ===== hdl/fof_ram.sv =====
`timescale 1ns / 1ps

// Generic single-write, single-read RAM with registered read data.
module fof_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/first_occurrence_filter_unit.sv =====
`timescale 1ns / 1ps

// First-occurrence filter: every word in gives one word out carrying the
// value, a keep flag (set when the value is not among those recorded in
// the current set), a copy of the last-of-set flag and a table overflow
// flag. New values are recorded in a RAM of TABLE_ENTRIES entries, filled
// in order; a fill count marks which entries belong to the current set, so
// no clearing pass is needed and the table is empty right after reset. The
// lookup is a linear scan through one comparator fed by the RAM read port:
// it stops at the first match or at the last filled entry and is skipped
// on an empty table. The block takes one word at a time: the next word is
// accepted only after the result is loaded into the output register, and
// that load waits while the register holds a stalled result. A full table
// keeps new values without recording them and raises table_overflow. A
// new word is accepted while a finished result still waits on the output
// register.
module first_occurrence_filter_unit
    import fof_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last_in_set,
    // output channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VALUE_W-1:0] o_value_out,
    output logic                      o_keep,
    output logic                      o_set_end,
    output logic                      o_table_overflow
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    t_state r_state, n_state;

    logic [CW-1:0]               r_count, n_count;
    logic [IW-1:0]               r_idx, n_idx;
    logic                        r_hit, n_hit;
    logic signed [VALUE_W-1:0]   r_value;
    logic                        r_last;

    logic                        r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0]   r_out_value;
    logic                        r_out_keep;
    logic                        r_out_set_end;
    logic                        r_out_ovf;

    logic                        in_accept;
    logic                        out_load;
    logic                        out_free;
    logic                        tbl_full;
    logic                        match;
    logic                        scan_last;
    logic                        wr_en;
    logic [IW-1:0]               rd_addr;
    logic [VALUE_W-1:0]          rd_data;

    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign tbl_full  = (r_count == FULL_COUNT);

    // Shared comparator: current RAM word against the held value.
    assign match     = (rd_data == r_value);
    assign scan_last = ((CW + 1)'(r_idx) + (CW + 1)'(1)) == (CW + 1)'(r_count);

    fof_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_seen_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (r_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_hit <= n_hit;
        if (in_accept) begin
            r_value <= i_value;
            r_last  <= i_last_in_set;
        end
        if (out_load) begin
            r_out_value   <= r_value;
            r_out_keep    <= !r_hit;
            r_out_set_end <= r_last;
            r_out_ovf     <= !r_hit && tbl_full;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        o_stall     = 1'b1;
        out_load    = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = '0;

        // drain the output register
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                n_idx   = '0;
                n_hit   = 1'b0;
                if (i_valid) begin
                    // empty table: nothing to compare
                    n_state = (r_count == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                // prefetch the next entry while comparing this one
                rd_addr = r_idx + IW'(1);
                if (match) begin
                    n_hit   = 1'b1;
                    n_state = S_FINISH;
                end else if (scan_last) begin
                    n_state = S_FINISH;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    wr_en       = !r_hit && !tbl_full;
                    if (r_last) begin
                        n_count = '0;
                    end else if (wr_en) begin
                        n_count = r_count + CW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_value_out      = r_out_value;
    assign o_keep           = r_out_keep;
    assign o_set_end        = r_out_set_end;
    assign o_table_overflow = r_out_ovf;

    // Fill count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("fill count above table size");

    // Scan index stays inside the filled part of the table.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((CW + 1)'(r_idx) < (CW + 1)'(r_count)))
        else $error("scan index beyond fill count");

    // A set end empties the table for the next set.
    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_last) |=> (r_count == '0))
        else $error("table not cleared after set end");

    // Overflow only on a kept word.
    a_ovf_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_overflow) |-> o_keep)
        else $error("overflow flagged on a duplicate");

endmodule

// ===== verif/first_occurrence_filter_checker.sv =====
`timescale 1ns / 1ps

module first_occurrence_filter_checker
    import fof_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last_in_set,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [VALUE_W-1:0] i_value_out,
    input  logic                      i_keep,
    input  logic                      i_set_end,
    input  logic                      i_table_overflow,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      keep;
        logic                      set_end;
        logic                      overflow;
    } t_dedup_word;

    logic signed [VALUE_W-1:0] recorded_values [TABLE_ENTRIES];
    int unsigned               recorded_count = 0;
    t_dedup_word               expected_words [$];
    int                        fail_count = 0;

    // Look the word up among this set's values, record it if new and not full.
    function automatic t_dedup_word filter_word(input logic signed [VALUE_W-1:0] value,
                                                input logic last);
        t_dedup_word w;
        logic        seen;
        int unsigned k;
        seen = 1'b0;
        for (k = 0; k < recorded_count; k++) begin
            if (recorded_values[k] == value) seen = 1'b1;
        end
        w.value    = value;
        w.keep     = !seen;
        w.set_end  = last;
        w.overflow = 1'b0;
        if (!seen) begin
            if (recorded_count < TABLE_ENTRIES) begin
                recorded_values[recorded_count] = value;
                recorded_count++;
            end else begin
                w.overflow = 1'b1;
            end
        end
        if (last) recorded_count = 0;
        return w;
    endfunction

    task automatic compare_field(input string field, input logic signed [VALUE_W:0] want,
                                 input logic signed [VALUE_W:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_dedup_word want;
        if (!i_rst_n) begin
            recorded_count = 0;
            expected_words.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(filter_word(i_value, i_last_in_set));
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("value_out: no word expected, got %0d", i_value_out);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    compare_field("value_out", want.value, i_value_out);
                    compare_field("keep", want.keep, i_keep);
                    compare_field("set_end", want.set_end, i_set_end);
                    compare_field("table_overflow", want.overflow, i_table_overflow);
                end
            end
            o_pending <= expected_words.size();
        end
        o_fail_count <= fail_count;
    end

endmodule

// ===== verif/first_occurrence_filter_unit_tb.sv =====
`timescale 1ns / 1ps

module first_occurrence_filter_unit_tb;
    import fof_pkg::*;

    localparam int unsigned TABLE_ENTRIES = 256;
    localparam int RANDOM_WORDS     = 1050;
    // A set long enough to fill the table and run past it.
    localparam int OVERFLOW_SET_LEN = 320;
    // Worst item: a full table scan plus both sides' longest gaps; the long
    // receiver hold-off is the longest legal quiet stretch.
    // Take the larger of the two several times over.
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int HOLD_OFF_AT      = 250;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 2 * TABLE_ENTRIES + 16;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic signed [VALUE_W-1:0] i_value       = '0;
    logic                      i_last_in_set = 1'b0;
    logic                      i_stall       = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic signed [VALUE_W-1:0] o_value_out;
    logic                      o_keep;
    logic                      o_set_end;
    logic                      o_table_overflow;

    int fail_count;
    int pending;
    int words_sent   = 0;
    int words_taken  = 0;
    int idle_cycles  = 0;
    bit sender_burst = 1'b0;

    always #4 i_clk = ~i_clk;

    first_occurrence_filter_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_value         (i_value),
        .i_last_in_set   (i_last_in_set),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_value_out     (o_value_out),
        .o_keep          (o_keep),
        .o_set_end       (o_set_end),
        .o_table_overflow(o_table_overflow)
    );

    first_occurrence_filter_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) filter_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_value         (i_value),
        .i_last_in_set   (i_last_in_set),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_value_out     (o_value_out),
        .i_keep          (o_keep),
        .i_set_end       (o_set_end),
        .i_table_overflow(o_table_overflow),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Offer one word after a random gap and hold it until the block takes it.
    // Drop valid only when a gap follows, so back-to-back words keep it high.
    task automatic send_word(input logic signed [VALUE_W-1:0] value, input logic last);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_value       <= value;
        i_last_in_set <= last;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
    endtask

    initial begin : stimulus
        int                        start_count;
        int                        len;
        int                        fresh;
        bit                        overflow_done;
        logic signed [VALUE_W-1:0] base;
        logic signed [VALUE_W-1:0] value;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes of the value range, repeats inside the set, and a set that
        // ends on a duplicate (keep low with set_end high).
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh7fff_ffff, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh7fff_ffff, 1'b0);
        send_word(1, 1'b0);
        send_word(-1, 1'b1);
        // One-word set whose value was seen in the set before: the table was
        // cleared, so it is kept again.
        send_word(32'sh8000_0000, 1'b1);
        // Same value three times, the last one closing the set.
        send_word(0, 1'b0);
        send_word(0, 1'b0);
        send_word(0, 1'b1);
        // Alternating bit patterns.
        send_word(32'shaaaa_aaaa, 1'b0);
        send_word(32'sh5555_5555, 1'b0);
        send_word(32'shaaaa_aaaa, 1'b1);

        start_count   = words_sent;
        overflow_done = 1'b0;
        while (words_sent - start_count < RANDOM_WORDS) begin
            sender_burst = ($urandom_range(0, 4) == 0);
            if (!overflow_done && words_sent - start_count >= 350) begin
                // Fill the table past its capacity. Mostly fresh values, some
                // repeats, which also hit values that overflowed and were not
                // recorded, so they come out kept and flagged again.
                overflow_done = 1'b1;
                base  = $urandom;
                fresh = 0;
                for (int i = 0; i < OVERFLOW_SET_LEN; i++) begin
                    if (fresh > 0 && $urandom_range(0, 7) == 0) begin
                        value = base + $urandom_range(0, fresh - 1);
                    end else begin
                        value = base + fresh;
                        fresh++;
                    end
                    send_word(value, i == OVERFLOW_SET_LEN - 1);
                end
            end else if ($urandom_range(0, 2) != 0) begin
                // Short set drawn from a pool of eight neighbors: plenty of
                // duplicates. Some pools straddle the signed and unsigned wraps.
                case ($urandom_range(0, 3))
                    0: begin
                        base = 32'sh7fff_fffc;
                    end
                    1: begin
                        base = -4;
                    end
                    default: begin
                        base = $urandom;
                    end
                endcase
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++)
                    send_word(base + $urandom_range(0, 7), i == len - 1);
            end else begin
                // Short set of full-range values, now and then repeating the
                // previous word.
                len   = $urandom_range(1, 12);
                value = $urandom;
                for (int i = 0; i < len; i++) begin
                    if (i == 0 || $urandom_range(0, 3) != 0) value = $urandom;
                    send_word(value, i == len - 1);
                end
            end
        end
        i_valid <= 1'b0;

        // Step the clock before checking, so the checker has counted the last word,
        // then hold until every result is in and watch for stray words.
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("first_occurrence_filter_unit: match");
        end else begin
            $display("first_occurrence_filter_unit: mismatch");
        end
        $finish;
    end

    // Receiver: stall a random number of cycles before each word, with runs of
    // no stalling, and once hold off long enough for the block to back up and
    // stall the sender.
    initial begin : receiver
        int gap;
        bit burst;
        bit held;
        burst = 1'b0;
        held  = 1'b0;
        forever begin
            if (!held && words_taken >= HOLD_OFF_AT) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 39) == 0) burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            words_taken++;
        end
    end

    // Watchdog: end the run when neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("first_occurrence_filter_unit: mismatch");
                $finish;
            end
        end
    end

endmodule
